@@ hdl/yolo_head_box_decode_assert.svh @@
// Assertion macros used by the checker file of the box decoder
`ifndef YOLO_HEAD_BOX_DECODE_ASSERT_SVH
`define YOLO_HEAD_BOX_DECODE_ASSERT_SVH

// Clocked property, held off while reset is asserted
`define YHBD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("yhbd assertion failed");

// Implication form of the above
`define YHBD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `YHBD_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

`endif

@@ hdl/yhbd_pkg.sv @@
// Types, constants and helper functions of the box decoder
package yhbd_pkg;

  localparam int NumClasses = 80;
  localparam int NumAnchors = 3;
  localparam int LastChannel = 4 + NumClasses;
  localparam int QueueDepth = 2;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_CONF_THR = 3'd0,
    REG_PAD_X    = 3'd1,
    REG_PAD_Y    = 3'd2,
    REG_SCALE_X  = 3'd3,
    REG_SCALE_Y  = 3'd4
  } reg_e;

  // Sequencer steps of the decode engine
  typedef enum logic [3:0] {
    ST_IDLE, ST_OBJ, ST_CLS, ST_CONF, ST_CX, ST_CY, ST_SQW, ST_W,
    ST_SQH, ST_H, ST_X1, ST_PX, ST_PY, ST_PW, ST_PH, ST_OUT
  } step_e;

  typedef struct packed {
    logic [15:0] conf_thr;
    logic [9:0]  pad_x;
    logic [9:0]  pad_y;
    logic [15:0] scale_x;
    logic [15:0] scale_y;
  } cfg_t;

  // One finished proposal handed from the front to the decode engine
  typedef struct packed {
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tw;
    logic signed [15:0] th;
    logic signed [15:0] obj;
    logic signed [15:0] best;
    logic signed [7:0]  cls;
    logic [1:0]         level;
    logic [6:0]         col;
    logic [6:0]         row;
    logic [1:0]         anc;
  } job_t;

  localparam logic [15:0] SigTab [17] = '{
    16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
    16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
    16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
  };

  localparam logic [8:0] AnchorTab [3][3][2] = '{
    '{'{9'd10, 9'd13}, '{9'd16, 9'd30}, '{9'd33, 9'd23}},
    '{'{9'd30, 9'd61}, '{9'd62, 9'd45}, '{9'd59, 9'd119}},
    '{'{9'd116, 9'd90}, '{9'd156, 9'd198}, '{9'd373, 9'd326}}
  };

  // Sigmoid of a Q8.8 value to Q0.16 by table and linear interpolation
  function automatic logic [15:0] sig_q16(input logic signed [15:0] x);
    logic [15:0] a;
    logic [8:0]  i;
    logic [6:0]  f;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [22:0] d;
    logic [15:0] y;
    a = x[15] ? 16'(-x) : 16'(x);
    i = a[15:7];
    f = a[6:0];
    if (i >= 9'd16) begin
      y = SigTab[16];
    end else begin
      lo = SigTab[{1'b0, i[3:0]}];
      hi = SigTab[5'({1'b0, i[3:0]} + 5'd1)];
      d  = 23'(hi - lo) * 23'(f);
      y  = lo + 16'(d >> 7);
    end
    return x[15] ? 16'(17'h10000 - 17'(y)) : y;
  endfunction

  function automatic logic [1:0] level_sat(input logic [1:0] level);
    return (level == 2'd3) ? 2'd2 : level;
  endfunction

  function automatic logic [2:0] stride_shift(input logic [1:0] level);
    logic [2:0] s;
    case (level_sat(level))
      2'd0:    s = 3'd3;
      2'd1:    s = 3'd4;
      default: s = 3'd5;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] anchor_sat(input logic [1:0] anc);
    int a;
    a = int'(anc);
    if (a >= NumAnchors) a = NumAnchors - 1;
    if (a > 2) a = 2;
    return 2'(a);
  endfunction

  // Corner coordinate: shift right by 28 toward zero, saturate to 14 bits
  function automatic logic signed [13:0] sat_edge(input logic signed [50:0] p);
    logic signed [50:0] n;
    logic signed [50:0] q;
    n = -p;
    q = p[50] ? -(n >>> 28) : (p >>> 28);
    if (q < -51'sd8192) q = -51'sd8192;
    if (q > 51'sd8191) q = 51'sd8191;
    return q[13:0];
  endfunction

  // Box size: shift right by 28, clamp at zero, saturate at the 14-bit maximum
  function automatic logic [13:0] sat_size(input logic signed [50:0] p);
    logic signed [50:0] q;
    q = p >>> 28;
    if (q > 51'sd16383) q = 51'sd16383;
    if (q < 51'sd0) q = 51'sd0;
    return q[13:0];
  endfunction

endpackage

@@ hdl/yhbd_queue.sv @@
// Two-entry proposal queue between front and decode engine
module yhbd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  yhbd_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output yhbd_pkg::job_t job_o
);
  import yhbd_pkg::*;

  job_t       mem_q [QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(QueueDepth));
  assign valid_o = (count_q != 2'd0);
  assign job_o   = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed proposal
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ hdl/yhbd_front.sv @@
// Front: accepts channel values, keeps per-proposal state, emits jobs
module yhbd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         scale_level_i,
  input  logic [6:0]         grid_col_i,
  input  logic [6:0]         grid_row_i,
  input  logic [1:0]         anchor_index_i,
  input  logic [6:0]         channel_i,
  input  logic signed [15:0] logit_i,
  input  logic               q_full_i,
  output logic               push_o,
  output yhbd_pkg::job_t      job_o
);
  import yhbd_pkg::*;

  logic signed [15:0] box_q [4];
  logic signed [15:0] obj_q;
  logic signed [15:0] best_q, best_d;
  logic signed [7:0]  cls_q, cls_d;
  logic               accept;
  logic [8:0]         ch9;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign ch9        = {2'b00, channel_i};

  // Track the best class logit
  always_comb begin
    best_d = best_q;
    cls_d  = cls_q;
    if (ch9 >= 9'd5 && ch9 <= 9'(LastChannel)) begin
      if (ch9 == 9'd5) begin
        best_d = (logit_i > 16'sd0) ? logit_i : 16'sd0;
        cls_d  = (logit_i > 16'sd0) ? 8'sd0 : -8'sd1;
      end else if (logit_i > best_q) begin
        best_d = logit_i;
        cls_d  = 8'(channel_i - 7'd5);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) box_q[k] <= '0;
      obj_q  <= '0;
      best_q <= '0;
      cls_q  <= -8'sd1;
    end else if (accept) begin
      if (ch9 < 9'd4) begin
        box_q[channel_i[1:0]] <= logit_i;
      end
      if (ch9 == 9'd4) begin
        obj_q <= logit_i;
      end
      best_q <= best_d;
      cls_q  <= cls_d;
    end
  end

  // Hand off a proposal on its last class channel
  assign push_o = accept && (ch9 == 9'(LastChannel));
  always_comb begin
    job_o.tx    = box_q[0];
    job_o.ty    = box_q[1];
    job_o.tw    = box_q[2];
    job_o.th    = box_q[3];
    job_o.obj   = obj_q;
    job_o.best  = best_d;
    job_o.cls   = cls_d;
    job_o.level = scale_level_i;
    job_o.col   = grid_col_i;
    job_o.row   = grid_row_i;
    job_o.anc   = anchor_index_i;
  end

endmodule

@@ hdl/yhbd_back.sv @@
// Decode engine: thresholds, box decode and rescale on one shared multiplier
module yhbd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  yhbd_pkg::cfg_t      cfg_i,
  input  logic               q_valid_i,
  input  yhbd_pkg::job_t      q_job_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [13:0] box_left_o,
  output logic signed [13:0] box_top_o,
  output logic [13:0]        box_width_o,
  output logic [13:0]        box_height_o,
  output logic signed [7:0]  class_id_o,
  output logic [15:0]        confidence_o
);
  import yhbd_pkg::*;

  step_e              state_q, state_d;
  job_t               job_q;
  logic [15:0]        so_q;
  logic [15:0]        conf_q;
  logic signed [31:0] cx_q, cy_q, x1_q, y1_q;
  logic [17:0]        sq_q;
  logic [27:0]        w_q, h_q;
  logic signed [13:0] left_q, top_q;
  logic [13:0]        wid_q, hgt_q;
  logic               out_valid_q;
  logic signed [13:0] out_left_q, out_top_q;
  logic [13:0]        out_wid_q, out_hgt_q;
  logic signed [7:0]  out_cls_q;
  logic [15:0]        out_conf_q;

  logic signed [15:0] sig_in;
  logic [15:0]        sig_out;
  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] prod;
  logic [6:0]         coord;
  logic signed [24:0] cval;
  logic [1:0]         anc;
  logic [1:0]         lvl;
  logic               out_free;
  logic               load_out;

  assign lvl      = level_sat(job_q.level);
  assign anc      = anchor_sat(job_q.anc);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_OUT) && out_free;
  assign q_pop_o  = (state_q == ST_IDLE) && q_valid_i;

  // Select the sigmoid operand for this step
  always_comb begin
    case (state_q)
      ST_OBJ:  sig_in = job_q.obj;
      ST_CLS:  sig_in = job_q.best;
      ST_CONF: sig_in = job_q.tx;
      ST_CX:   sig_in = job_q.tx;
      ST_CY:   sig_in = job_q.ty;
      ST_SQW:  sig_in = job_q.tw;
      ST_SQH:  sig_in = job_q.th;
      default: sig_in = job_q.tx;
    endcase
  end
  assign sig_out = sig_q16(sig_in);

  // Select multiplier operands for this step
  always_comb begin
    case (state_q)
      ST_CLS: begin
        mul_a = 33'(so_q);
        mul_b = 18'(sig_out);
      end
      ST_SQW, ST_SQH: begin
        mul_a = 33'({sig_out, 1'b0});
        mul_b = 18'({sig_out, 1'b0});
      end
      ST_W: begin
        mul_a = 33'(sq_q);
        mul_b = 18'(AnchorTab[lvl][anc][0]);
      end
      ST_H: begin
        mul_a = 33'(sq_q);
        mul_b = 18'(AnchorTab[lvl][anc][1]);
      end
      ST_PX: begin
        mul_a = 33'(x1_q);
        mul_b = 18'(cfg_i.scale_x);
      end
      ST_PY: begin
        mul_a = 33'(y1_q);
        mul_b = 18'(cfg_i.scale_y);
      end
      ST_PW: begin
        mul_a = 33'(w_q);
        mul_b = 18'(cfg_i.scale_x);
      end
      ST_PH: begin
        mul_a = 33'(h_q);
        mul_b = 18'(cfg_i.scale_y);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = 51'(mul_a) * 51'(mul_b);

  // Center offset within the grid, before the stride
  assign coord = (state_q == ST_CY) ? job_q.row : job_q.col;
  assign cval  = $signed(25'({sig_out, 1'b0})) - 25'sd32768
               + $signed({2'b00, coord, 16'h0000});

  // Step through the decode
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_OBJ;
      ST_OBJ:  state_d = (sig_out < cfg_i.conf_thr) ? ST_IDLE : ST_CLS;
      ST_CLS:  state_d = ST_CONF;
      ST_CONF: state_d = (conf_q < cfg_i.conf_thr) ? ST_IDLE : ST_CX;
      ST_CX:   state_d = ST_CY;
      ST_CY:   state_d = ST_SQW;
      ST_SQW:  state_d = ST_W;
      ST_W:    state_d = ST_SQH;
      ST_SQH:  state_d = ST_H;
      ST_H:    state_d = ST_X1;
      ST_X1:   state_d = ST_PX;
      ST_PX:   state_d = ST_PY;
      ST_PY:   state_d = ST_PW;
      ST_PW:   state_d = ST_PH;
      ST_PH:   state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_job_i;
    case (state_q)
      ST_OBJ:  so_q   <= sig_out;
      ST_CLS:  conf_q <= prod[31:16];
      ST_CX:   cx_q   <= 32'(cval) <<< stride_shift(job_q.level);
      ST_CY:   cy_q   <= 32'(cval) <<< stride_shift(job_q.level);
      ST_SQW:  sq_q   <= prod[33:16];
      ST_W:    w_q    <= prod[27:0];
      ST_SQH:  sq_q   <= prod[33:16];
      ST_H:    h_q    <= prod[27:0];
      ST_X1: begin
        x1_q <= cx_q - $signed({5'b0, w_q[27:1]})
              - $signed({6'b0, cfg_i.pad_x, 16'h0000});
        y1_q <= cy_q - $signed({5'b0, h_q[27:1]})
              - $signed({6'b0, cfg_i.pad_y, 16'h0000});
      end
      ST_PX:   left_q <= sat_edge(prod);
      ST_PY:   top_q  <= sat_edge(prod);
      ST_PW:   wid_q  <= sat_size(prod);
      ST_PH:   hgt_q  <= sat_size(prod);
      default: ;
    endcase
    if (load_out) begin
      out_left_q <= left_q;
      out_top_q  <= top_q;
      out_wid_q  <= wid_q;
      out_hgt_q  <= hgt_q;
      out_cls_q  <= job_q.cls;
      out_conf_q <= conf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign box_left_o   = out_left_q;
  assign box_top_o    = out_top_q;
  assign box_width_o  = out_wid_q;
  assign box_height_o = out_hgt_q;
  assign class_id_o   = out_cls_q;
  assign confidence_o = out_conf_q;

endmodule

@@ hdl/yolo_head_box_decode.sv @@
// A kept box is presented after its last class channel is taken and the proposal
// has passed the queue and engine. Throughput: one channel value per cycle while
// the two-entry queue has room; the engine takes one proposal at a time, ends a
// dropped one early at a threshold check and waits while the output is stalled.
// Reset: asynchronous, active low; clears control and the proposal state and
// loads the register defaults. No memory clearing pass.
module yolo_head_box_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         scale_level_i,
  input  logic [6:0]         grid_col_i,
  input  logic [6:0]         grid_row_i,
  input  logic [1:0]         anchor_index_i,
  input  logic [6:0]         channel_i,
  input  logic signed [15:0] logit_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [13:0] box_left_o,
  output logic signed [13:0] box_top_o,
  output logic [13:0]        box_width_o,
  output logic [13:0]        box_height_o,
  output logic signed [7:0]  class_id_o,
  output logic [15:0]        confidence_o
);
  import yhbd_pkg::*;

  cfg_t cfg_q;
  job_t push_job, q_job;
  logic push, q_full, q_valid, q_pop;
  logic wr_en;
  reg_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_e'(paddr[4:2]);

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_thr <= 16'd32768;
      cfg_q.pad_x    <= 10'd0;
      cfg_q.pad_y    <= 10'd0;
      cfg_q.scale_x  <= 16'd4096;
      cfg_q.scale_y  <= 16'd4096;
    end else if (wr_en) begin
      case (idx)
        REG_CONF_THR: cfg_q.conf_thr <= pwdata[15:0];
        REG_PAD_X:    cfg_q.pad_x    <= pwdata[9:0];
        REG_PAD_Y:    cfg_q.pad_y    <= pwdata[9:0];
        REG_SCALE_X:  cfg_q.scale_x  <= pwdata[15:0];
        REG_SCALE_Y:  cfg_q.scale_y  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (idx)
      REG_CONF_THR: prdata = 32'(cfg_q.conf_thr);
      REG_PAD_X:    prdata = 32'(cfg_q.pad_x);
      REG_PAD_Y:    prdata = 32'(cfg_q.pad_y);
      REG_SCALE_X:  prdata = 32'(cfg_q.scale_x);
      REG_SCALE_Y:  prdata = 32'(cfg_q.scale_y);
      default:      prdata = '0;
    endcase
  end

  yhbd_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .scale_level_i,
    .grid_col_i,
    .grid_row_i,
    .anchor_index_i,
    .channel_i,
    .logit_i,
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  yhbd_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  yhbd_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_job_i   (q_job),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .box_left_o,
    .box_top_o,
    .box_width_o,
    .box_height_o,
    .class_id_o,
    .confidence_o
  );

endmodule

@@ hdl/yhbd_checker.sv @@
// Port-level checker for the box decoder and its bind
`include "yolo_head_box_decode_assert.svh"
module yhbd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [4:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         scale_level_i,
  input logic [6:0]         grid_col_i,
  input logic [6:0]         grid_row_i,
  input logic [1:0]         anchor_index_i,
  input logic [6:0]         channel_i,
  input logic signed [15:0] logit_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [13:0] box_left_o,
  input logic signed [13:0] box_top_o,
  input logic [13:0]        box_width_o,
  input logic [13:0]        box_height_o,
  input logic signed [7:0]  class_id_o,
  input logic [15:0]        confidence_o
);
  import yhbd_pkg::*;

  // A stalled result transaction keeps its payload
  `YHBD_ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, ##1 (out_valid_o && $stable(box_left_o) && $stable(box_top_o) && $stable(box_width_o) && $stable(box_height_o) && $stable(class_id_o) && $stable(confidence_o)))
  // Reported class is no class or a valid index
  `YHBD_ASSERT_IMP(a_class_range, clk_i, rst_ni, out_valid_o, (class_id_o >= -8'sd1) && (int'(class_id_o) < NumClasses))
  // The register port never waits
  `YHBD_ASSERT(a_pready, clk_i, rst_ni, pready)

endmodule

bind yolo_head_box_decode yhbd_checker u_yhbd_checker (.*);
